// ----- src/iwt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_pkg: shared types and constants
// Slot table sizes, op codes, register indexes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package iwt_pkg;

  localparam int SLOTS     = 64;
  localparam int BUCKETS   = 64;
  localparam int IDX_W     = 6;
  localparam int BKT_W     = 6;
  localparam int CNT_W     = 7;
  localparam int IVL_W     = 16;
  localparam int KA_W      = 20;
  localparam int TURN_W    = 23;
  localparam int ENTRY_W   = BKT_W + KA_W;
  localparam int DIV_STEPS = 20;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] OP_REFRESH = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_BUCKETS  = 1'b1;

  localparam logic [CNT_W-1:0] BUCKETS_RESET = 7'd10;

  typedef struct packed {
    logic ready;
    logic load_item;
    logic remove;
    logic ref_ovf_wr;
    logic ref_div_start;
    logic ref_wheel_wr;
    logic rd_issue;
    logic idx_inc;
    logic take_hit;
    logic adv_bucket;
    logic ovf_div_start;
    logic ovf_sub_wr;
    logic ovf_move_wr;
    logic push_final;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       enabled;
    logic       cand_wheel;
    logic       cand_ovf;
    logic       hit;
    logic       pend_valid;
    logic       out_free;
    logic       idx_last;
    logic       fits;
    logic       below_turn;
    logic       div_busy;
    logic       wraps;
  } status_t;

endpackage

// ----- src/iwt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iwt_ram #(
  parameter int Width = 26,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/iwt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_div: serial restoring divider
// 20-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iwt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [iwt_pkg::KA_W-1:0]  dividend_i,
  input  logic [iwt_pkg::IVL_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [iwt_pkg::KA_W-1:0]  quotient_o
);

  logic                          busy_q, busy_d;
  logic [iwt_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [iwt_pkg::IVL_W-1:0]     rem_q, rem_d;
  logic [iwt_pkg::KA_W-1:0]      quo_q, quo_d;
  logic [iwt_pkg::IVL_W-1:0]     dvs_q, dvs_d;
  logic [iwt_pkg::IVL_W:0]       shifted;
  logic [iwt_pkg::IVL_W:0]       trial;

  assign shifted = {rem_q, quo_q[iwt_pkg::KA_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iwt_pkg::DIV_CNT_W'(iwt_pkg::DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = trial[iwt_pkg::IVL_W-1:0];
        quo_d = {quo_q[iwt_pkg::KA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[iwt_pkg::IVL_W-1:0];
        quo_d = {quo_q[iwt_pkg::KA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/iwt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_datapath: slot table, bucket index, divider and result register
// Executes the controller's commands and reports status back.
// ----------------------------------------------------------------------------
module iwt_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  iwt_pkg::cmd_t             cmd_i,
  output iwt_pkg::status_t          status_o,
  input  logic [iwt_pkg::IVL_W-1:0] interval_i,
  input  logic [iwt_pkg::CNT_W-1:0] bucket_count_i,
  input  logic [1:0]                in_op_i,
  input  logic [iwt_pkg::IDX_W-1:0] in_slot_i,
  input  logic [iwt_pkg::KA_W-1:0]  in_alive_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      out_expired_o,
  output logic [iwt_pkg::IDX_W-1:0] out_slot_o,
  output logic                      out_last_o
);

  logic [iwt_pkg::SLOTS-1:0]     valid_q, valid_d;
  logic [iwt_pkg::SLOTS-1:0]     ovf_q, ovf_d;
  logic [iwt_pkg::BKT_W-1:0]     cur_q, cur_d;
  logic [iwt_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [iwt_pkg::IDX_W-1:0]     slot_q;
  logic [iwt_pkg::KA_W-1:0]      alive_q;
  logic [iwt_pkg::TURN_W-1:0]    remain_q, turn_q;
  logic                          pend_q, pend_d;
  logic [iwt_pkg::IDX_W-1:0]     pend_slot_q, pend_slot_d;
  logic                          ov_q, ov_d;
  logic                          oexp_q, oexp_d;
  logic [iwt_pkg::IDX_W-1:0]     oslot_q, oslot_d;
  logic                          olast_q, olast_d;

  logic [iwt_pkg::CNT_W-1:0]     cnt;
  logic [iwt_pkg::CNT_W-1:0]     cnt_left;
  logic [iwt_pkg::TURN_W-1:0]    remain_d, turn_d;
  logic [iwt_pkg::CNT_W-1:0]     cur_next;
  logic                          out_free;
  logic [iwt_pkg::ENTRY_W-1:0]   rdata;
  logic [iwt_pkg::BKT_W-1:0]     rd_bucket;
  logic [iwt_pkg::KA_W-1:0]      rd_excess;
  logic                          we;
  logic [iwt_pkg::IDX_W-1:0]     waddr;
  logic [iwt_pkg::ENTRY_W-1:0]   wdata;
  logic                          div_start;
  logic                          div_busy;
  logic [iwt_pkg::KA_W-1:0]      div_dividend;
  logic [iwt_pkg::KA_W-1:0]      quotient;

  // bucket count clamped to 1..BUCKETS
  always_comb begin
    if (bucket_count_i == '0) begin
      cnt = iwt_pkg::CNT_W'(1);
    end else if (bucket_count_i > iwt_pkg::CNT_W'(iwt_pkg::BUCKETS)) begin
      cnt = iwt_pkg::CNT_W'(iwt_pkg::BUCKETS);
    end else begin
      cnt = bucket_count_i;
    end
  end

  assign cnt_left = cnt - {1'b0, cur_q};
  assign remain_d = ({1'b0, cur_q} < cnt) ? cnt_left * interval_i : '0;
  assign turn_d   = cnt * interval_i;
  assign cur_next = {1'b0, cur_q} + 1'b1;

  assign rd_bucket = rdata[iwt_pkg::ENTRY_W-1:iwt_pkg::KA_W];
  assign rd_excess = rdata[iwt_pkg::KA_W-1:0];
  assign out_free  = !ov_q || out_ready_i;

  assign div_start    = cmd_i.ref_div_start || cmd_i.ovf_div_start;
  assign div_dividend = cmd_i.ref_div_start ? alive_q : rd_excess;

  iwt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (interval_i),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // table write port
  always_comb begin
    we    = cmd_i.ref_ovf_wr || cmd_i.ref_wheel_wr || cmd_i.ovf_sub_wr || cmd_i.ovf_move_wr;
    waddr = (cmd_i.ref_ovf_wr || cmd_i.ref_wheel_wr) ? slot_q : idx_q;
    wdata = '0;
    if (cmd_i.ref_ovf_wr) begin
      wdata = {{iwt_pkg::BKT_W{1'b0}}, alive_q - remain_q[iwt_pkg::KA_W-1:0]};
    end else if (cmd_i.ref_wheel_wr) begin
      wdata = {cur_q + quotient[iwt_pkg::BKT_W-1:0], {iwt_pkg::KA_W{1'b0}}};
    end else if (cmd_i.ovf_sub_wr) begin
      wdata = {{iwt_pkg::BKT_W{1'b0}}, rd_excess - turn_q[iwt_pkg::KA_W-1:0]};
    end else if (cmd_i.ovf_move_wr) begin
      wdata = {quotient[iwt_pkg::BKT_W-1:0], {iwt_pkg::KA_W{1'b0}}};
    end
  end

  iwt_ram #(
    .Width (iwt_pkg::ENTRY_W),
    .Depth (iwt_pkg::SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    valid_d     = valid_q;
    ovf_d       = ovf_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    ov_d        = ov_q && !out_ready_i;
    oexp_d      = oexp_q;
    oslot_d     = oslot_q;
    olast_d     = olast_q;

    if (cmd_i.load_item) begin
      idx_d = '0;
    end
    if (cmd_i.remove) begin
      valid_d[in_slot_i] = 1'b0;
      ovf_d[in_slot_i]   = 1'b0;
    end
    if (cmd_i.ref_ovf_wr || cmd_i.ref_wheel_wr) begin
      valid_d[slot_q] = 1'b1;
      ovf_d[slot_q]   = cmd_i.ref_ovf_wr;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.ovf_move_wr) begin
      ovf_d[idx_q] = 1'b0;
    end
    // expired slot is held back one step so the last one can carry the flag
    if (cmd_i.take_hit) begin
      valid_d[idx_q] = 1'b0;
      pend_d         = 1'b1;
      pend_slot_d    = idx_q;
      if (pend_q) begin
        ov_d    = 1'b1;
        oexp_d  = 1'b1;
        oslot_d = pend_slot_q;
        olast_d = 1'b0;
      end
    end
    if (cmd_i.adv_bucket) begin
      idx_d = '0;
      if (cur_next >= cnt) begin
        cur_d = '0;
      end else begin
        cur_d = cur_next[iwt_pkg::BKT_W-1:0];
      end
    end
    if (cmd_i.push_final) begin
      ov_d    = 1'b1;
      oexp_d  = pend_q;
      oslot_d = pend_q ? pend_slot_q : '0;
      olast_d = 1'b1;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ovf_q   <= '0;
      cur_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ovf_q   <= ovf_d;
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    oexp_q      <= oexp_d;
    oslot_q     <= oslot_d;
    olast_q     <= olast_d;
    if (cmd_i.load_item) begin
      slot_q   <= in_slot_i;
      alive_q  <= in_alive_i;
      remain_q <= remain_d;
      turn_q   <= turn_d;
    end
  end

  always_comb begin
    status_o.in_op      = in_op_i;
    status_o.enabled    = interval_i != '0;
    status_o.cand_wheel = valid_q[idx_q] && !ovf_q[idx_q];
    status_o.cand_ovf   = valid_q[idx_q] && ovf_q[idx_q];
    status_o.hit        = rd_bucket == cur_q;
    status_o.pend_valid = pend_q;
    status_o.out_free   = out_free;
    status_o.idx_last   = idx_q == iwt_pkg::IDX_W'(iwt_pkg::SLOTS - 1);
    status_o.fits       = {3'b000, alive_q} < remain_q;
    status_o.below_turn = {3'b000, rd_excess} < turn_q;
    status_o.div_busy   = div_busy;
    status_o.wraps      = cur_next >= cnt;
  end

  assign out_valid_o   = ov_q;
  assign out_expired_o = oexp_q;
  assign out_slot_o    = oslot_q;
  assign out_last_o    = olast_q;

endmodule

// ----- src/iwt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwt_ctrl: sequencing state machine
// Steps refresh, remove and tick requests through the datapath.
// ----------------------------------------------------------------------------
module iwt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  iwt_pkg::status_t status_i,
  output iwt_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REF_DEC = 4'd1;
  localparam logic [3:0] S_REF_DIV = 4'd2;
  localparam logic [3:0] S_T1_CHK  = 4'd3;
  localparam logic [3:0] S_T1_EV   = 4'd4;
  localparam logic [3:0] S_T_ADV   = 4'd5;
  localparam logic [3:0] S_T2_CHK  = 4'd6;
  localparam logic [3:0] S_T2_EV   = 4'd7;
  localparam logic [3:0] S_T2_DIV  = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_FIN;
          case (status_i.in_op)
            iwt_pkg::OP_REFRESH: if (status_i.enabled) state_d = S_REF_DEC;
            iwt_pkg::OP_REMOVE:  cmd_o.remove = 1'b1;
            iwt_pkg::OP_TICK:    if (status_i.enabled) state_d = S_T1_CHK;
            default:             state_d = S_FIN;
          endcase
        end
      end
      S_REF_DEC: begin
        if (status_i.fits) begin
          cmd_o.ref_div_start = 1'b1;
          state_d = S_REF_DIV;
        end else begin
          cmd_o.ref_ovf_wr = 1'b1;
          state_d = S_FIN;
        end
      end
      S_REF_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.ref_wheel_wr = 1'b1;
          state_d = S_FIN;
        end
      end
      S_T1_CHK: begin
        if (status_i.cand_wheel) begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_T1_EV;
        end else if (status_i.idx_last) begin
          state_d = S_T_ADV;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_T1_EV: begin
        if (!(status_i.hit && status_i.pend_valid && !status_i.out_free)) begin
          cmd_o.take_hit = status_i.hit;
          if (status_i.idx_last) begin
            state_d = S_T_ADV;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_T1_CHK;
          end
        end
      end
      S_T_ADV: begin
        cmd_o.adv_bucket = 1'b1;
        state_d = status_i.wraps ? S_T2_CHK : S_FIN;
      end
      S_T2_CHK: begin
        if (status_i.cand_ovf) begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_T2_EV;
        end else if (status_i.idx_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_T2_EV: begin
        if (status_i.below_turn) begin
          cmd_o.ovf_div_start = 1'b1;
          state_d = S_T2_DIV;
        end else begin
          cmd_o.ovf_sub_wr = 1'b1;
          cmd_o.idx_inc = !status_i.idx_last;
          state_d = status_i.idx_last ? S_FIN : S_T2_CHK;
        end
      end
      S_T2_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.ovf_move_wr = 1'b1;
          cmd_o.idx_inc = !status_i.idx_last;
          state_d = status_i.idx_last ? S_FIN : S_T2_CHK;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.push_final = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/idle_connection_timing_wheel_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_connection_timing_wheel_unit: keepalive timing wheel, 64 slots
// Top level: APB registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one request: tuser = op (refresh/remove/tick),
//    tdata = slot and keepalive seconds. One request at a time.
//  - Master stream returns expired slots (tuser = expired flag, tdata = slot),
//    tlast on the final result of a request. A request with nothing expired
//    yields a single result with the flag low.
//  - Sequencing: a refresh parked in overflow goes straight to its result; one
//    that fits first runs the 20-step serial divider; a remove needs no scan. A
//    tick scans all 64 slot entries (only wheel slots are read from the RAM), and
//    on a wheel wrap scans again, adding a divider pass per overflow entry
//    moved in.
//  - Slot data sits in a 64-entry RAM; live and overflow flags are flops
//    cleared at reset, so no clearing pass is needed after reset.
//  - Master stall: the output register holds, the scan waits, and the next
//    request is accepted once the final result has gone to the register.
//  - APB: interval at 0x0, bucket count at 0x4; write only while idle.
// ----------------------------------------------------------------------------
module idle_connection_timing_wheel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [5:0] slot, [25:6] keepalive_seconds
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] expired_slot
  output logic        m_axis_tuser,   // [0] expired_valid
  output logic        m_axis_tlast
);

  logic [iwt_pkg::IVL_W-1:0] interval_q;
  logic [iwt_pkg::CNT_W-1:0] buckets_q;
  logic                      cfg_wr;
  iwt_pkg::cmd_t             cmd;
  iwt_pkg::status_t          status;
  logic [iwt_pkg::IDX_W-1:0] out_slot;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      buckets_q  <= iwt_pkg::BUCKETS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        iwt_pkg::REG_INTERVAL: interval_q <= pwdata[iwt_pkg::IVL_W-1:0];
        iwt_pkg::REG_BUCKETS:  buckets_q  <= pwdata[iwt_pkg::CNT_W-1:0];
        default:               interval_q <= interval_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      iwt_pkg::REG_INTERVAL: prdata = {16'd0, interval_q};
      iwt_pkg::REG_BUCKETS:  prdata = {25'd0, buckets_q};
      default:               prdata = '0;
    endcase
  end

  iwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign s_axis_tready = cmd.ready;

  iwt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .interval_i     (interval_q),
    .bucket_count_i (buckets_q),
    .in_op_i        (s_axis_tuser),
    .in_slot_i      (s_axis_tdata[5:0]),
    .in_alive_i     (s_axis_tdata[25:6]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_expired_o  (m_axis_tuser),
    .out_slot_o     (out_slot),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_slot};

endmodule

// ----- dv/tb_idle_connection_timing_wheel_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_idle_connection_timing_wheel_unit: self-checking bench for the wheel
// Drives refresh, remove and tick requests under varied register settings and
// stream back-pressure, predicts the expired-slot results with its own wheel
// model, and compares every returned result field by field in order.
// ----------------------------------------------------------------------------
module tb_idle_connection_timing_wheel_unit;

  typedef struct packed {
    logic       expired;
    logic [5:0] slot;
    logic       last;
  } expiry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  idle_connection_timing_wheel_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // wheel shadow
  logic [iwt_pkg::IVL_W-1:0] ivl_q;
  logic [iwt_pkg::CNT_W-1:0] cnt_q;
  logic                      live_q [iwt_pkg::SLOTS];
  logic                      park_q [iwt_pkg::SLOTS];
  logic [iwt_pkg::BKT_W-1:0] bkt_q  [iwt_pkg::SLOTS];
  logic [iwt_pkg::KA_W-1:0]  xs_q   [iwt_pkg::SLOTS];
  int unsigned               cur_q;

  expiry_t expiry_fifo[$];
  int      n_errors = 0;
  int      tx_idle = 0, rx_idle = 0;
  int      quiet_cycles = 0;
  localparam int QUIET_LIMIT = 40000;

  task automatic report(input string what, input expiry_t got, input expiry_t exp);
    $display("mismatch %s: got v=%0b s=%0d l=%0b exp v=%0b s=%0d l=%0b", what,
             got.expired, got.slot, got.last, exp.expired, exp.slot, exp.last);
    n_errors++;
  endtask

  function automatic int unsigned eff_buckets();
    if (cnt_q == 0) return 1;
    if (cnt_q > iwt_pkg::BUCKETS) return iwt_pkg::BUCKETS;
    return cnt_q;
  endfunction

  // Advance the shadow wheel by one request and queue the expected results.
  task automatic predict_expiry(input logic [1:0] op, input logic [5:0] s,
                                input logic [19:0] ka);
    int unsigned c, remain, turn;
    int          n;
    expiry_t     e;
    c = eff_buckets();
    n = 0;
    if (op == iwt_pkg::OP_REFRESH && ivl_q != 0) begin
      remain = (cur_q < c) ? (c - cur_q) * ivl_q : 0;
      live_q[s] = 1'b1;
      if (ka >= remain) begin
        park_q[s] = 1'b1;
        xs_q[s]   = 20'(ka - remain);
        bkt_q[s]  = '0;
      end else begin
        park_q[s] = 1'b0;
        xs_q[s]   = '0;
        bkt_q[s]  = 6'(cur_q + ka / ivl_q);
      end
    end else if (op == iwt_pkg::OP_REMOVE) begin
      live_q[s] = 1'b0; park_q[s] = 1'b0; bkt_q[s] = '0; xs_q[s] = '0;
    end else if (op == iwt_pkg::OP_TICK && ivl_q != 0) begin
      turn = ivl_q * c;
      for (int i = 0; i < iwt_pkg::SLOTS; i++)
        if (live_q[i] && !park_q[i] && bkt_q[i] == cur_q) begin
          e.expired = 1'b1; e.slot = 6'(i); e.last = 1'b0;
          expiry_fifo = {expiry_fifo, e};
          n++;
          live_q[i] = 1'b0;
          bkt_q[i]  = '0;
        end
      cur_q++;
      if (cur_q >= c) begin
        cur_q = 0;
        for (int i = 0; i < iwt_pkg::SLOTS; i++)
          if (live_q[i] && park_q[i]) begin
            if (xs_q[i] < turn) begin
              park_q[i] = 1'b0;
              bkt_q[i]  = 6'(xs_q[i] / ivl_q);
              xs_q[i]   = '0;
            end else xs_q[i] = 20'(xs_q[i] - turn);
          end
      end
    end
    if (n == 0) begin
      e = '{expired: 1'b0, slot: '0, last: 1'b1};
      expiry_fifo = {expiry_fifo, e};
    end else expiry_fifo[$].last = 1'b1;
  endtask

  // one request over the slave stream; tvalid stays up for back-to-back items
  task automatic send_request(input logic [1:0] op, input logic [5:0] s,
                              input logic [19:0] ka);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, ka, s};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_expiry(op, s, ka);
  endtask

  // wait for all results, then let any trailing scan finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expiry_fifo.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == iwt_pkg::REG_INTERVAL) ivl_q = val[iwt_pkg::IVL_W-1:0];
    else cnt_q = val[iwt_pkg::CNT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    reg_write(iwt_pkg::REG_INTERVAL, 32'd10);
    reg_write(iwt_pkg::REG_BUCKETS, 32'd4);
    send_request(iwt_pkg::OP_REFRESH, 6'd0, 20'd0);          // current bucket
    send_request(iwt_pkg::OP_REFRESH, 6'd63, 20'hFFFFF);     // deep in overflow
    send_request(iwt_pkg::OP_REFRESH, 6'd5, 20'd39);         // last bucket of turn
    send_request(iwt_pkg::OP_REFRESH, 6'd6, 20'd40);         // exactly one turn: overflow
    send_request(iwt_pkg::OP_REFRESH, 6'd7, 20'd15);
    send_request(iwt_pkg::OP_REFRESH, 6'd7, 20'd25);         // overwrite of live slot
    send_request(iwt_pkg::OP_REMOVE,  6'd5, 20'hFFFFF);
    send_request(2'd3,                6'd63, 20'hFFFFF);     // undefined op
    repeat (6) send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);  // crosses a wrap
    settle();
    // disabled: refresh and tick do nothing, remove still clears
    reg_write(iwt_pkg::REG_INTERVAL, 32'd0);
    send_request(iwt_pkg::OP_REFRESH, 6'd9, 20'd1);
    send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);
    send_request(iwt_pkg::OP_REMOVE, 6'd63, 20'd0);
    settle();
  endtask

  task automatic test_bucket_count_limits();
    reg_write(iwt_pkg::REG_INTERVAL, 32'hFFFF);
    reg_write(iwt_pkg::REG_BUCKETS, 32'd127);                // clamps to the maximum
    send_request(iwt_pkg::OP_REFRESH, 6'd1, 20'd70000);
    send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);
    send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);
    settle();
    reg_write(iwt_pkg::REG_INTERVAL, 32'd1);
    reg_write(iwt_pkg::REG_BUCKETS, 32'd0);                  // used as one
    send_request(iwt_pkg::OP_REFRESH, 6'd2, 20'd0);
    send_request(iwt_pkg::OP_REFRESH, 6'd3, 20'd3);
    repeat (4) send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);
    settle();
    // raise the count and step the index, then lower the count while the index sits past it
    reg_write(iwt_pkg::REG_BUCKETS, 32'd8);
    repeat (5) send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);
    send_request(iwt_pkg::OP_REFRESH, 6'd4, 20'd6);
    settle();
    reg_write(iwt_pkg::REG_BUCKETS, 32'd2);
    send_request(iwt_pkg::OP_REFRESH, 6'd8, 20'd1);          // no turn left: parked
    repeat (3) send_request(iwt_pkg::OP_TICK, 6'd0, 20'd0);
    settle();
  endtask

  task automatic test_random_mix(input int items);
    int unsigned pick, ka_span;
    logic [1:0]  op;
    logic [19:0] ka;
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) begin
        settle();
        case ($urandom_range(3))
          0: begin
            reg_write(iwt_pkg::REG_INTERVAL, 32'd1);
            reg_write(iwt_pkg::REG_BUCKETS, 32'd1);
          end
          1: begin
            reg_write(iwt_pkg::REG_INTERVAL, 32'hFFFF);
            reg_write(iwt_pkg::REG_BUCKETS, 32'd64);
          end
          default: begin
            reg_write(iwt_pkg::REG_INTERVAL, $urandom_range(1, 20));
            reg_write(iwt_pkg::REG_BUCKETS, $urandom_range(1, 12));
          end
        endcase
      end
      pick = $urandom_range(99);
      op = (pick < 50) ? iwt_pkg::OP_REFRESH : (pick < 65) ? iwt_pkg::OP_REMOVE :
           (pick < 96) ? iwt_pkg::OP_TICK : 2'd3;
      ka_span = ivl_q * eff_buckets() * 3;
      if ($urandom_range(9) == 0 || ka_span > 20'hFFFFF) ka = 20'($urandom);
      else ka = 20'($urandom_range(ka_span));
      send_request(op, 6'($urandom_range(63)), ka);
    end
    settle();
  endtask

  // receiver back-pressure
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rx_idle);

  // result checker and watchdog
  always @(posedge clk_i) begin
    expiry_t got;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (psel && penable) ||
          (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{expired: m_axis_tuser, slot: m_axis_tdata[5:0], last: m_axis_tlast};
        if (expiry_fifo.size() == 0) report("unexpected", got, got);
        else if (got !== expiry_fifo[0]) report("field", got, expiry_fifo.pop_front());
        else void'(expiry_fifo.pop_front());
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
        $display("** idle_connection_timing_wheel_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    ivl_q = '0;
    cnt_q = iwt_pkg::BUCKETS_RESET;
    cur_q = 0;
    for (int i = 0; i < iwt_pkg::SLOTS; i++) begin
      live_q[i] = 1'b0; park_q[i] = 1'b0; bkt_q[i] = '0; xs_q[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle = 37; rx_idle = 47;
    test_directed();
    test_bucket_count_limits();
    test_random_mix(150);
    tx_idle = 47; rx_idle = 37;
    test_random_mix(150);
    tx_idle = 0; rx_idle = 0;
    test_random_mix(150);
    if (expiry_fifo.size() != 0) begin
      $display("%0d results never arrived", expiry_fifo.size());
      n_errors++;
    end
    if (n_errors == 0) $display("** idle_connection_timing_wheel_unit: PASSED **");
    else $display("** idle_connection_timing_wheel_unit: FAILED **");
    $finish;
  end

endmodule
